FILE: rtl/sbus_frame_receiver_assert.svh
// Assertion macros shared by the frame receiver modules.
`ifndef SBUS_FRAME_RECEIVER_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define SBFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define SBFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sbfr_pkg.sv
// Shared constants and types for the frame receiver.
`default_nettype none

package sbfr_pkg;

  localparam int FRAME_LENGTH = 25;
  localparam int POS_W        = 5;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] END_POS = POS_W'(FRAME_LENGTH - 1);

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam int CH_W       = 11;
  localparam int NUM_CH     = 8;
  localparam int FRAME_BITS = NUM_CH * CH_W;
  localparam int STORE_LAST = FRAME_BITS / 8;
  localparam int STORE_IDX_W = $clog2(STORE_LAST + 1);

  // Channel numbers (from zero) of the two mode switches.
  localparam int SW_A_CH = 2;
  localparam int SW_B_CH = 7;

  localparam logic [CH_W-1:0] THRESHOLD_RESET = CH_W'(1500);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((FRAME_BITS + 1 + 7) / 8) * 8;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Frame bytes 1 to 11 packed little-endian: channel k sits at bit 11*k.
  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sbfr_front.sv
// Front end: hunts for the start byte, counts and stores frame bytes.
`default_nettype none

module sbfr_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     byte_valid_i,
  output logic                          byte_ready_o,
  input  wire logic [7:0]               byte_i,
  input  wire sbfr_pkg::q_stat_t        q_stat_i,
  output logic                          push_o,
  output sbfr_pkg::frame_t              push_data_o
);

  logic [sbfr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0] store_q [1:sbfr_pkg::STORE_LAST];
  logic       accept;
  logic       frame_end;
  logic       store_en;

  assign byte_ready_o = !q_stat_i.full;
  assign accept       = byte_valid_i && byte_ready_o;
  assign frame_end    = (pos_q >= sbfr_pkg::END_POS) && (byte_i == sbfr_pkg::END_BYTE);
  assign push_o       = accept && (pos_q != '0) && frame_end;
  assign store_en     = accept && (pos_q != '0) && !frame_end &&
                        (pos_q <= sbfr_pkg::POS_W'(sbfr_pkg::STORE_LAST));

  always_comb begin
    for (int i = 1; i <= sbfr_pkg::STORE_LAST; i++) begin
      push_data_o[8*(i-1) +: 8] = store_q[i];
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (pos_q == '0) begin
        if (byte_i == sbfr_pkg::START_BYTE) begin
          pos_d = sbfr_pkg::POS_W'(1);
        end
      end else if (frame_end) begin
        pos_d = '0;
      end else if (pos_q != sbfr_pkg::POS_MAX) begin
        pos_d = pos_q + sbfr_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      store_q[pos_q[sbfr_pkg::STORE_IDX_W-1:0]] <= byte_i;
    end
  end

`include "sbus_frame_receiver_assert.svh"
  `SBFR_ASSERT_NEXT(a_push_restarts_hunt, push_o, pos_q == '0, "front: position not cleared after frame end")
  `SBFR_ASSERT_NEXT(a_hunt_ignores_noise, accept && (pos_q == '0) && (byte_i != sbfr_pkg::START_BYTE), pos_q == '0, "front: left hunting on a non-start byte")
  `SBFR_ASSERT(a_no_push_when_full, !(push_o && q_stat_i.full), "front: frame pushed into a full queue")

endmodule

`default_nettype wire

FILE: rtl/sbfr_queue.sv
// Short queue of completed frames between the front and back ends.
`default_nettype none

module sbfr_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sbfr_pkg::frame_t  push_data_i,
  input  wire logic              pop_i,
  output sbfr_pkg::frame_t       pop_data_o,
  output sbfr_pkg::q_stat_t      stat_o
);

  sbfr_pkg::frame_t mem_q [sbfr_pkg::Q_DEPTH];
  logic [sbfr_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [sbfr_pkg::Q_CNT_W-1:0] count_q;

  assign stat_o.full  = (count_q == sbfr_pkg::Q_CNT_W'(sbfr_pkg::Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == sbfr_pkg::Q_PTR_W'(sbfr_pkg::Q_DEPTH - 1)) ?
                    '0 : wr_ptr_q + sbfr_pkg::Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == sbfr_pkg::Q_PTR_W'(sbfr_pkg::Q_DEPTH - 1)) ?
                    '0 : rd_ptr_q + sbfr_pkg::Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + sbfr_pkg::Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - sbfr_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sbfr_back.sv
// Back end: checks the mode switches and holds the result for the output.
`default_nettype none

module sbfr_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sbfr_pkg::CH_W-1:0]     cfg_wdata_i,
  input  wire sbfr_pkg::q_stat_t             q_stat_i,
  input  wire sbfr_pkg::frame_t              frame_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sbfr_pkg::OUT_TDATA_W-1:0]   out_data_o
);

  logic [sbfr_pkg::CH_W-1:0] threshold_q;
  logic                      latched_q, latched_d;
  logic                      out_valid_q;
  sbfr_pkg::frame_t          frame_q;
  logic                      entered_q, entered_d;
  logic [sbfr_pkg::CH_W-1:0] sw_a, sw_b;

  assign sw_a  = frame_i[sbfr_pkg::SW_A_CH*sbfr_pkg::CH_W +: sbfr_pkg::CH_W];
  assign sw_b  = frame_i[sbfr_pkg::SW_B_CH*sbfr_pkg::CH_W +: sbfr_pkg::CH_W];
  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    latched_d = latched_q;
    entered_d = 1'b0;
    if (pop_o && !latched_q && (sw_a > threshold_q) && (sw_b > threshold_q)) begin
      latched_d = 1'b1;
      entered_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= sbfr_pkg::THRESHOLD_RESET;
      latched_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        threshold_q <= cfg_wdata_i;
      end
      latched_q <= latched_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_q   <= frame_i;
      entered_q <= entered_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(sbfr_pkg::OUT_TDATA_W - sbfr_pkg::FRAME_BITS - 1)'(0),
                        entered_q, frame_q};

`include "sbus_frame_receiver_assert.svh"
  `SBFR_ASSERT(a_latch_sticks, !$fell(latched_q), "back: remote mode latch cleared")
  `SBFR_ASSERT(a_entered_implies_latched, !(out_valid_q && entered_q) || latched_q, "back: beep request without latched remote mode")
  `SBFR_ASSERT_NEXT(a_pop_fills_output, pop_o, out_valid_q, "back: popped frame not presented")

endmodule

`default_nettype wire

FILE: rtl/sbus_frame_receiver.sv
// Top level of the serial-bus frame receiver with remote-mode switch.
//
// Input channel (s_axis): one received serial byte per item. While hunting,
// every byte other than the start byte 0x0F is dropped. After the start byte
// the bytes are counted (saturating at 31); bytes 1 to 11 are kept. Once at
// least 24 bytes of the frame are held, a 0x00 byte closes the frame.
// Output channel (m_axis): one item per closed frame carrying the eight
// 11-bit channels and the entered_remote flag. The flag is 1 only for the
// frame that first sees channels 3 and 8 above switch_threshold; it asks
// for a short beep and latches remote mode until reset.
// Configuration: cfg_we_i writes cfg_wdata_i into switch_threshold in the
// same cycle; write it only while no frame is in flight.
// The closing byte queues its frame; the pop of that frame sets m_axis_tvalid_o.
// Throughput: one byte per cycle. A two-entry frame queue parts the byte
// front end from the result register, so bytes keep flowing while a result
// waits; s_axis_tready_o drops only once two finished frames are queued
// behind a stalled output.
// Reset: hunting for the start byte, threshold 1500, remote mode clear,
// queue and output empty.
`default_nettype none

module sbus_frame_receiver (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [sbfr_pkg::CH_W-1:0]          cfg_wdata_i,      // switch_threshold
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [sbfr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,   // rx_byte
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // From bit 0 up: channel_1 .. channel_8 (11 bits each), entered_remote, zero pad.
  output logic [sbfr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o
);

  sbfr_pkg::q_stat_t q_stat;
  sbfr_pkg::frame_t  push_data;
  sbfr_pkg::frame_t  pop_data;
  logic              push;
  logic              pop;

  sbfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_o (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  sbfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  sbfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_stat_i    (q_stat),
    .frame_i     (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

FILE: tb/sbus_frame_receiver_tb.sv
// Self-checking testbench for the serial-bus frame receiver with remote-mode switch.
`default_nettype none

module sbus_frame_receiver_tb;

  localparam int NUM_CH      = sbfr_pkg::NUM_CH;
  localparam int CH_W        = sbfr_pkg::CH_W;
  localparam int POS_W       = sbfr_pkg::POS_W;
  localparam int STORE_LAST  = sbfr_pkg::STORE_LAST;
  localparam int FRAME_BITS  = sbfr_pkg::FRAME_BITS;
  localparam int IN_TDATA_W  = sbfr_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = sbfr_pkg::OUT_TDATA_W;
  localparam int SW_A_CH     = sbfr_pkg::SW_A_CH;
  localparam int SW_B_CH     = sbfr_pkg::SW_B_CH;
  localparam logic [POS_W-1:0] END_POS = sbfr_pkg::END_POS;
  localparam logic [POS_W-1:0] POS_MAX = sbfr_pkg::POS_MAX;
  localparam logic [7:0] START_BYTE = sbfr_pkg::START_BYTE;
  localparam logic [7:0] END_BYTE   = sbfr_pkg::END_BYTE;
  localparam logic [CH_W-1:0] THRESHOLD_RESET = sbfr_pkg::THRESHOLD_RESET;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int STORE_DEPTH  = STORE_LAST + 1;
  localparam int PHASE_ITEMS  = 270;
  localparam int REPORT_LIMIT = 10;

  // One decoded frame as it leaves the block: channel_1 sits in chan[0].
  typedef struct packed {
    logic                           entered;
    logic [NUM_CH-1:0][CH_W-1:0]    chan;
  } frame_result_t;

  // One directed frame: optional threshold write, hunting noise ahead of the
  // start byte, channel payload, filler bytes, and a typed-in result if the
  // outcome is obvious by inspection.
  typedef struct {
    bit                             has_cfg;
    logic [CH_W-1:0]                cfg;
    int                             lead_cnt;
    logic [7:0]                     lead;
    logic [NUM_CH-1:0][CH_W-1:0]    chan;
    int                             fill_cnt;
    logic [7:0]                     fill;
    bit                             has_exp;
    logic                           entered;
  } frame_plan_t;

  logic                       clk_i;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [CH_W-1:0]            cfg_wdata = '0;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [IN_TDATA_W-1:0]      s_tdata   = '0;
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0]     m_tdata;

  // Predictor copy of the block state.
  logic [POS_W-1:0]           rx_pos = '0;
  logic [7:0]                 rx_store [STORE_DEPTH];
  logic                       remote_on = 1'b0;
  logic [CH_W-1:0]            thr_q = THRESHOLD_RESET;

  frame_result_t              frames_due [$];
  bit                         typed_pending = 1'b0;
  frame_result_t              typed_frame;

  int                         src_idle  = 0;
  int                         dst_stall = 0;
  int                         items_counted = 0;
  int                         mismatch_count = 0;
  int                         cycle_count = 0;

  // Directed frames. Rows with has_exp clear are checked against the predictor.
  frame_plan_t plan [10] = '{
    // Hunting noise, all-zero payload, zero filler before the frame may end.
    '{1'b0, 11'd0, 3, 8'hFF, {8{11'd0}}, 12, 8'h00, 1'b1, 1'b0},
    // Zero byte while hunting; both switch channels equal to the threshold.
    '{1'b0, 11'd0, 1, 8'h00, {8{11'd1500}}, 12, 8'h55, 1'b1, 1'b0},
    // Only channel 3 above the threshold; start byte used as filler.
    '{1'b0, 11'd0, 0, 8'h00,
      {11'd1500, 11'd300, 11'd1234, 11'd5, 11'd700, 11'd2047, 11'd1024, 11'd1},
      12, START_BYTE, 1'b1, 1'b0},
    // Only channel 8 above the threshold.
    '{1'b0, 11'd0, 0, 8'h00,
      {11'd2047, 11'd77, 11'd1999, 11'd1501, 11'd2046, 11'd1500, 11'd0, 11'd2047},
      12, 8'hC3, 1'b1, 1'b0},
    // Maximum threshold: full-scale channels are not strictly above it.
    '{1'b1, 11'd2047, 0, 8'h00, {8{11'd2047}}, 12, 8'hFF, 1'b1, 1'b0},
    // Zero threshold with zero channels.
    '{1'b1, 11'd0, 0, 8'h00, {8{11'd0}}, 12, 8'h80, 1'b1, 1'b0},
    // Long frame: the byte counter saturates before the closing byte.
    '{1'b0, 11'd0, 0, 8'h00,
      {11'd0, 11'd1365, 11'd682, 11'd1, 11'd2000, 11'd2047, 11'd1023, 11'd1024},
      45, 8'hFF, 1'b0, 1'b0},
    // Back to the reset threshold; full-scale switches latch remote mode.
    '{1'b1, 11'd1500, 0, 8'h00, {8{11'd2047}}, 12, 8'hFF, 1'b1, 1'b1},
    // Same frame again: already latched, so no second beep.
    '{1'b0, 11'd0, 0, 8'h00, {8{11'd2047}}, 12, 8'hAA, 1'b1, 1'b0},
    '{1'b0, 11'd0, 2, 8'h0E,
      {11'd1111, 11'd222, 11'd1717, 11'd1600, 11'd404, 11'd1601, 11'd999, 11'd12},
      20, 8'h33, 1'b0, 1'b0}
  };

  sbus_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Advances the predicted state by one received byte. Returns 1 when the
  // byte closes a frame, with the decoded frame in res.
  function automatic bit decode_rx_byte(input logic [7:0] b, output frame_result_t res);
    logic [FRAME_BITS-1:0] bits;
    res = '0;
    if (rx_pos == '0) begin
      if (b == START_BYTE) begin
        rx_store[0] = b;
        rx_pos = POS_W'(1);
      end
      return 1'b0;
    end
    if (rx_pos >= END_POS && b == END_BYTE) begin
      // Bytes 1 to 11 form one little-endian bit string of eight channels.
      for (int i = 1; i <= STORE_LAST; i++) begin
        bits[8*(i-1) +: 8] = rx_store[i];
      end
      res.chan = bits;
      if (!remote_on && res.chan[SW_A_CH] > thr_q && res.chan[SW_B_CH] > thr_q) begin
        remote_on = 1'b1;
        res.entered = 1'b1;
      end
      rx_pos = '0;
      return 1'b1;
    end
    if (rx_pos < STORE_DEPTH) rx_store[rx_pos] = b;
    if (rx_pos != POS_MAX) rx_pos = rx_pos + 1'b1;
    return 1'b0;
  endfunction

  // Offers one byte, with random idle cycles ahead of it, and records the
  // frame it completes, if any.
  task automatic send_rx_byte(input logic [7:0] b);
    frame_result_t res;
    bit            ignored;
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_tready);
    ignored = (rx_pos == '0) && (b != START_BYTE);
    if (decode_rx_byte(b, res)) begin
      frames_due.push_back(typed_pending ? typed_frame : res);
      typed_pending = 1'b0;
    end
    if (!ignored) items_counted++;
  endtask

  // Stops sending and waits until every frame due has come out.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [CH_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    thr_q      = value;
  endtask

  // Mostly well-formed frames with random content, plus line noise and
  // frames whose filler holds a stray zero byte that closes them early.
  task automatic run_random_phase(input int src_pct, input int dst_pct, input int target);
    int         first_count;
    int         kind;
    int         n;
    logic [7:0] b;
    wait_idle();
    write_threshold(CH_W'($urandom_range(0, 2047)));
    src_idle    = src_pct;
    dst_stall   = dst_pct;
    first_count = items_counted;
    while (items_counted - first_count < target) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) send_rx_byte(8'($urandom_range(0, 255)));
      end else begin
        send_rx_byte(START_BYTE);
        repeat (STORE_LAST) begin
          if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          else b = 8'($urandom_range(0, 255));
          send_rx_byte(b);
        end
        if (kind <= 5) n = 12;
        else if (kind <= 7) n = $urandom_range(13, 24);
        else n = $urandom_range(25, 45);
        repeat (n) begin
          b = ($urandom_range(0, 9) == 0) ? END_BYTE : 8'($urandom_range(1, 255));
          send_rx_byte(b);
        end
        send_rx_byte(END_BYTE);
      end
    end
    // Close any frame still open so the next threshold write finds the block idle.
    while (rx_pos != '0) send_rx_byte((rx_pos >= END_POS) ? END_BYTE : 8'h5A);
  endtask

  // Result side: check each accepted frame, then pick the next ready level.
  always @(posedge clk_i) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got.chan    = m_tdata[FRAME_BITS-1:0];
      got.entered = m_tdata[FRAME_BITS];
      if (frames_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected frame: chan %h entered %b", got.chan, got.entered);
      end else begin
        want = frames_due.pop_front();
        if (got.chan != want.chan || got.entered != want.entered) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("frame mismatch: expected chan %h entered %b, got chan %h entered %b",
                     want.chan, want.entered, got.chan, got.entered);
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= dst_stall);
  end

  initial begin
    logic [FRAME_BITS-1:0] bits;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    src_idle  = 20;
    dst_stall = 65;
    foreach (plan[r]) begin
      if (plan[r].has_cfg) begin
        wait_idle();
        write_threshold(plan[r].cfg);
      end
      repeat (plan[r].lead_cnt) send_rx_byte(plan[r].lead);
      send_rx_byte(START_BYTE);
      bits = plan[r].chan;
      for (int i = 1; i <= STORE_LAST; i++) send_rx_byte(bits[8*(i-1) +: 8]);
      repeat (plan[r].fill_cnt) send_rx_byte(plan[r].fill);
      typed_pending       = plan[r].has_exp;
      typed_frame.chan    = plan[r].chan;
      typed_frame.entered = plan[r].entered;
      send_rx_byte(END_BYTE);
    end

    run_random_phase(20, 65, PHASE_ITEMS);
    run_random_phase(65, 20, PHASE_ITEMS);
    run_random_phase(0, 0, PHASE_ITEMS);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
